// ----- sv/dtls_replay_window_check_unit_defines.svh -----
// Assertion macros shared by the replay window check RTL.
// Needs a clk and an active-high rst in the scope of each use.
`ifndef DTLS_REPLAY_WINDOW_CHECK_UNIT_DEFINES_SVH
`define DTLS_REPLAY_WINDOW_CHECK_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DRW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define DRW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/dtlsrw_pkg.sv -----
// Shared types and constants of the DTLS replay window check.
// No dependencies.
package dtlsrw_pkg;

  localparam int REC_W      = 64;
  localparam int SEQ_W      = 48;
  localparam int EPOCH_W    = 16;
  localparam int HIGH_LSB   = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Register byte addresses (one register, word spaced)
  localparam logic [CFG_ADDR_W-1:0] REG_EXPECTED_EPOCH = 3'h0;

  typedef enum logic [1:0] {
    V_ACCEPT  = 2'd0,
    V_EPOCH   = 2'd1,
    V_OUTSIDE = 2'd2,
    V_REPLAY  = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ADV_HIGH,
    ST_ADV_LOW,
    ST_FINISH
  } state_t;

  // Control broadcast along the row of bitmap cells
  typedef struct packed {
    logic shift;
    logic set;
  } cell_ctl_t;

endpackage

// ----- sv/dtlsrw_cell.sv -----
// One bit of the received bitmap: shifts from its upper neighbour or is set.
// Depends on dtlsrw_pkg.
module dtlsrw_cell #(
  parameter int IDX_W = 6,
  parameter int IDX   = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dtlsrw_pkg::cell_ctl_t ctl,
  input  logic [IDX_W-1:0]     set_pos,
  input  logic                 upper,
  output logic                 q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= 1'b0;
    end else if (ctl.shift) begin
      q <= upper;
    end else if (ctl.set && (set_pos == IDX_W'(IDX))) begin
      q <= 1'b1;
    end
  end

endmodule

// ----- sv/dtlsrw_ctrl.sv -----
// Sequencer: epoch and window checks, window advance, result register.
// Depends on dtlsrw_pkg; drives the row of dtlsrw_cell instances.
module dtlsrw_ctrl #(
  parameter int WINDOW_BITS = 64,
  parameter int IDX_W       = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dtlsrw_pkg::REC_W-1:0]      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output dtlsrw_pkg::verdict_t              out_verdict,
  input  logic [dtlsrw_pkg::EPOCH_W-1:0]    expected_epoch,
  input  logic [WINDOW_BITS-1:0]            bitmap,
  output dtlsrw_pkg::cell_ctl_t             ctl,
  output logic [IDX_W-1:0]                  set_pos,
  output logic [dtlsrw_pkg::SEQ_W-1:0]      window_base
);

  localparam int SEQ_W = dtlsrw_pkg::SEQ_W;

  dtlsrw_pkg::state_t   state, state_next;
  dtlsrw_pkg::verdict_t verdict, verdict_next;
  logic [dtlsrw_pkg::REC_W-1:0] record;

  logic [SEQ_W:0]   sub;
  logic [SEQ_W-1:0] diff;
  logic             epoch_ok, in_window, high_any, out_load;

  // Sequence minus base: borrow means not above the base
  assign sub       = {1'b0, record[SEQ_W-1:0]} - {1'b0, window_base};
  assign diff      = sub[SEQ_W-1:0];
  assign epoch_ok  = (record[dtlsrw_pkg::REC_W-1:SEQ_W] == expected_epoch);
  assign in_window = !sub[SEQ_W] && (diff != '0) && (diff <= SEQ_W'(WINDOW_BITS));
  assign set_pos   = diff[IDX_W-1:0] - IDX_W'(1);
  assign high_any  = |bitmap[WINDOW_BITS-1:dtlsrw_pkg::HIGH_LSB];
  assign out_load  = (state == dtlsrw_pkg::ST_FINISH) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtlsrw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    verdict_next = verdict;
    in_ready     = 1'b0;
    ctl          = '0;
    case (state)
      dtlsrw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = dtlsrw_pkg::ST_CHECK;
        end
      end
      dtlsrw_pkg::ST_CHECK: begin
        if (!epoch_ok) begin
          verdict_next = dtlsrw_pkg::V_EPOCH;
        end else if (!in_window) begin
          verdict_next = dtlsrw_pkg::V_OUTSIDE;
        end else if (bitmap[set_pos]) begin
          verdict_next = dtlsrw_pkg::V_REPLAY;
        end else begin
          verdict_next = dtlsrw_pkg::V_ACCEPT;
        end
        if (verdict_next == dtlsrw_pkg::V_ACCEPT) begin
          ctl.set    = 1'b1;
          state_next = dtlsrw_pkg::ST_ADV_HIGH;
        end else begin
          state_next = dtlsrw_pkg::ST_FINISH;
        end
      end
      dtlsrw_pkg::ST_ADV_HIGH: begin
        ctl.shift  = high_any;
        state_next = dtlsrw_pkg::ST_ADV_LOW;
      end
      dtlsrw_pkg::ST_ADV_LOW: begin
        if (bitmap[0]) begin
          ctl.shift = 1'b1;
        end else begin
          state_next = dtlsrw_pkg::ST_FINISH;
        end
      end
      dtlsrw_pkg::ST_FINISH: begin
        if (out_load) begin
          state_next = dtlsrw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dtlsrw_pkg::ST_IDLE;
      end
    endcase
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      record <= in_data;
    end
    verdict <= verdict_next;
    if (out_load) begin
      out_verdict <= verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      window_base <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.shift) begin
        window_base <= window_base + SEQ_W'(1);
      end
    end
  end

endmodule

// ----- sv/dtls_replay_window_check_unit.sv -----
// Top level of the DTLS anti-replay window check: stream ports, APB register.
// Depends on dtlsrw_pkg, dtlsrw_cell, dtlsrw_ctrl and the defines header.
//
// Each input beat carries one 64-bit DTLS record number (epoch in bits 63..48,
// sequence in 47..0) and yields exactly one output beat with a verdict: accept,
// wrong epoch, outside window or replayed duplicate. The record is checked
// against expected_epoch (APB register at byte address 0) and against a window
// of WINDOW_BITS sequences above window_base; an accepted record sets its bit
// in a bitmap held in a row of one-bit cells. The window then advances one
// sequence per clock by shifting the cell row down: one step if any bit at
// position 16 or above is set, then one step per contiguous set bit at the
// bottom. A rejected record goes from IDLE through CHECK to FINISH; an
// accepted record goes through CHECK, ADV_HIGH and ADV_LOW to FINISH, where
// ADV_HIGH is passed whether or not it shifts. After an upper-part step the
// top bit is clear, so the run of set bits at the bottom is at most
// WINDOW_BITS - 1 long. In FINISH the result is parked in the output register
// once that register is free. One record is worked on at a time; the next
// input beat is taken as soon as the result is parked in the output register,
// even if that result has not yet been taken downstream. Reset clears bitmap,
// base and epoch.
`include "dtls_replay_window_check_unit_defines.svh"

module dtls_replay_window_check_unit #(
  parameter int WINDOW_BITS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Input stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [63:0]                           s_tdata,   // [63:0] record_number
  // Result stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [7:0]                            m_tdata,   // [1:0] verdict, [7:2] zero
  // APB register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [dtlsrw_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [dtlsrw_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [dtlsrw_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                  pready
);

  localparam int IDX_W = $clog2(WINDOW_BITS);

  logic [dtlsrw_pkg::EPOCH_W-1:0] expected_epoch;
  logic [WINDOW_BITS-1:0]         bitmap;
  logic [WINDOW_BITS-1:0]         shift_in;
  logic [IDX_W-1:0]               set_pos;
  logic [dtlsrw_pkg::SEQ_W-1:0]   window_base;
  dtlsrw_pkg::cell_ctl_t          ctl;
  dtlsrw_pkg::verdict_t           verdict;
  logic                           reg_hit;

  // Register port: writes complete in the access cycle, never wait
  assign pready  = 1'b1;
  assign reg_hit = (paddr[dtlsrw_pkg::CFG_ADDR_W-1:2] ==
                    dtlsrw_pkg::REG_EXPECTED_EPOCH[dtlsrw_pkg::CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_epoch <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      expected_epoch <= pwdata[dtlsrw_pkg::EPOCH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(dtlsrw_pkg::CFG_DATA_W - dtlsrw_pkg::EPOCH_W){1'b0}}, expected_epoch};
    end
  end

  // Sequencer
  dtlsrw_ctrl #(
    .WINDOW_BITS (WINDOW_BITS),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .in_data        (s_tdata),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_verdict    (verdict),
    .expected_epoch (expected_epoch),
    .bitmap         (bitmap),
    .ctl            (ctl),
    .set_pos        (set_pos),
    .window_base    (window_base)
  );

  assign m_tdata = {6'b0, verdict};

  // Cell row: each cell takes its upper neighbour's bit on a shift; zero enters at the top
  assign shift_in = {1'b0, bitmap[WINDOW_BITS-1:1]};

  for (genvar k = 0; k < WINDOW_BITS; k++) begin : g_cell
    dtlsrw_cell #(
      .IDX_W (IDX_W),
      .IDX   (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .set_pos (set_pos),
      .upper   (shift_in[k]),
      .q       (bitmap[k])
    );
  end

  // Checks on the window logic
  `DRW_ASSERT_NEXT(a_shift_moves_row, ctl.shift, bitmap == ($past(bitmap) >> 1), "bitmap did not shift by one")
  `DRW_ASSERT_NEXT(a_shift_bumps_base, ctl.shift, window_base == ($past(window_base) + 48'd1), "base did not advance with the shift")
  `DRW_ASSERT_NEXT(a_set_adds_one, ctl.set, $countones(bitmap) == ($countones($past(bitmap)) + 1), "accept did not set a fresh bit")
  `DRW_ASSERT_IMP(a_no_take_while_shifting, ctl.shift, !s_tready, "input taken during window advance")

endmodule
